FILE: design/qvr_pkg.sv
// Shared widths, register indexes, types and the first rounding step of the
// quaternion vector rotation pipeline. Used by every module in design/ but qvr_checker.
// No dependencies.
package qvr_pkg;

  localparam int VW   = 16;  // vector component and register width
  localparam int QW   = 17;  // quaternion part after optional negation
  localparam int TW   = 20;  // T = round(2 (q x v)), fits 20 bits signed
  localparam int PW   = 37;  // one product, 17 x 20 bits
  localparam int CW   = 38;  // difference of two products
  localparam int SW   = 39;  // three-term sum of the second pass
  localparam int RW   = 25;  // rounded correction term
  localparam int FRAC = 14;  // Q2.14 fraction bits

  localparam int NUM_REGS = 4;
  localparam logic [1:0] REG_ROT_W = 2'd0;
  localparam logic [1:0] REG_ROT_X = 2'd1;
  localparam logic [1:0] REG_ROT_Y = 2'd2;
  localparam logic [1:0] REG_ROT_Z = 2'd3;

  typedef logic signed [VW-1:0] vcomp_t;
  typedef logic signed [QW-1:0] qcomp_t;
  typedef logic signed [TW-1:0] tcomp_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [RW-1:0] rcomp_t;

  // Both halves of a cross product, one pair per axis: c[i] = pos[i] - neg[i].
  typedef struct packed {
    prod_t [2:0] pos;
    prod_t [2:0] neg;
  } xprod_t;

  // Result group handed from the saturation stage to the ports.
  typedef struct packed {
    logic         saturated;
    vcomp_t       w;
    vcomp_t [2:0] v;
  } result_t;

  // T = round((pos - neg) / 2^(FRAC-1)), ties toward plus infinity.
  function automatic tcomp_t round_t(prod_t pos, prod_t neg);
    logic signed [CW-1:0] diff;
    logic signed [CW-1:0] shifted;
    diff    = CW'(pos) - CW'(neg) + CW'(64'sd1 <<< (FRAC - 2));
    shifted = diff >>> (FRAC - 1);
    return shifted[TW-1:0];
  endfunction

endpackage

FILE: design/qvr_xprod.sv
// Registered cross-product halves a x b for the rotation pipeline.
// Depends on qvr_pkg (types and widths).
module qvr_xprod (
  input  logic                    clk,
  input  logic                    en,
  input  qvr_pkg::qcomp_t [2:0]   a,
  input  qvr_pkg::tcomp_t [2:0]   b,
  output qvr_pkg::xprod_t         prod_r
);

  qvr_pkg::xprod_t prod_nxt;

  always_comb begin
    prod_nxt.pos[0] = qvr_pkg::prod_t'(a[1]) * qvr_pkg::prod_t'(b[2]);
    prod_nxt.neg[0] = qvr_pkg::prod_t'(a[2]) * qvr_pkg::prod_t'(b[1]);
    prod_nxt.pos[1] = qvr_pkg::prod_t'(a[2]) * qvr_pkg::prod_t'(b[0]);
    prod_nxt.neg[1] = qvr_pkg::prod_t'(a[0]) * qvr_pkg::prod_t'(b[2]);
    prod_nxt.pos[2] = qvr_pkg::prod_t'(a[0]) * qvr_pkg::prod_t'(b[1]);
    prod_nxt.neg[2] = qvr_pkg::prod_t'(a[1]) * qvr_pkg::prod_t'(b[0]);
  end

  // hold on stall
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

FILE: design/qvr_sat.sv
// Final stage: add the correction to the vector, clamp to 16 bits, flag clamps.
// Depends on qvr_pkg (types and widths).
module qvr_sat (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_in,
  input  qvr_pkg::rcomp_t [2:0]  r,
  input  qvr_pkg::vcomp_t [2:0]  v,
  input  qvr_pkg::vcomp_t        w,
  output logic                   vld_r,
  output qvr_pkg::result_t       res_r
);

  localparam int AW = qvr_pkg::RW + 1;
  localparam logic signed [AW-1:0] MAX_V = AW'(32767);
  localparam logic signed [AW-1:0] MIN_V = -AW'(32768);

  qvr_pkg::result_t res_nxt;

  always_comb begin
    logic signed [AW-1:0] s;
    logic                 hit;
    hit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s = AW'(v[i]) + AW'(r[i]);
      if (s > MAX_V) begin
        res_nxt.v[i] = 16'sh7fff;
        hit          = 1'b1;
      end else if (s < MIN_V) begin
        res_nxt.v[i] = 16'sh8000;
        hit          = 1'b1;
      end else begin
        res_nxt.v[i] = s[qvr_pkg::VW-1:0];
      end
    end
    res_nxt.w         = w;
    res_nxt.saturated = hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: design/quaternion_vector_rotation.sv
// Top level of the fixed-point quaternion vector rotation pipeline.
// Depends on qvr_pkg, qvr_xprod and qvr_sat.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+---------------------------------------
//  in_     | in  | in_tvalid/in_tready | tdata vec_x..vec_w, tuser mode
//  out_    | out | out_tvalid/tready   | tdata out_x..out_w, tuser saturated
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index (rot_w,x,y,z), cfg_data
//
// One request enters per cycle unless a stall on out_tready holds the pipeline.
// The six register stages are: input capture, q x v products, T rounding,
// second-pass products, sum and rounding, add and clamp.
// The whole pipeline advances together whenever the output register is empty
// or drained, so a stall on out_tready holds every stage and drops nothing.
// Synchronous active-low reset clears the valid bits and loads the identity
// rotation. cfg_ready is always high; write registers only while idle.
module quaternion_vector_rotation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // vec_x [15:0], vec_y [31:16], vec_z [47:32], vec_w [63:48]
  input  logic [0:0]  in_tuser,   // mode [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_x [15:0], out_y [31:16], out_z [47:32], out_w [63:48]
  output logic [0:0]  out_tuser,  // saturated [0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int VW = qvr_pkg::VW;

  // Quaternion registers
  qvr_pkg::vcomp_t rot_w_r, rot_x_r, rot_y_r, rot_z_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_w_r <= 16'sd16384;
      rot_x_r <= '0;
      rot_y_r <= '0;
      rot_z_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        qvr_pkg::REG_ROT_W: rot_w_r <= cfg_data;
        qvr_pkg::REG_ROT_X: rot_x_r <= cfg_data;
        qvr_pkg::REG_ROT_Y: rot_y_r <= cfg_data;
        qvr_pkg::REG_ROT_Z: rot_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline advance: move everything when the output register can take a result.
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Valid bits for stages 0..4; stage 5 lives in qvr_sat.
  logic [4:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_tvalid};
    end
  end

  // Stage 0: capture the request and apply the conjugate when mode is set.
  qvr_pkg::qcomp_t [2:0] q0_r, q1_r, q2_r;
  qvr_pkg::vcomp_t [2:0] v0_r, v1_r, v2_r, v3_r, v4_r;
  qvr_pkg::vcomp_t       w0_r, w1_r, w2_r, w3_r, w4_r;
  qvr_pkg::qcomp_t [2:0] q0_nxt;
  qvr_pkg::qcomp_t [2:0] q_raw;

  assign q_raw[0] = qvr_pkg::qcomp_t'(rot_x_r);
  assign q_raw[1] = qvr_pkg::qcomp_t'(rot_y_r);
  assign q_raw[2] = qvr_pkg::qcomp_t'(rot_z_r);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // 17 bits hold the negated most negative part without wrapping
      q0_nxt[i] = in_tuser[0] ? -q_raw[i] : q_raw[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q0_r <= q0_nxt;
      for (int i = 0; i < 3; i++) begin
        v0_r[i] <= in_tdata[VW*i +: VW];
      end
      w0_r <= in_tdata[VW*3 +: VW];
    end
  end

  // Stage 1: products of q x v.
  qvr_pkg::tcomp_t [2:0] v0_ext;
  qvr_pkg::xprod_t       xp1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v0_ext[i] = qvr_pkg::tcomp_t'(v0_r[i]);
    end
  end

  qvr_xprod u_xprod_qv (
    .clk    (clk),
    .en     (adv),
    .a      (q0_r),
    .b      (v0_ext),
    .prod_r (xp1_r)
  );

  // Stage 2: T = round(2 (q x v)) at integer scale.
  qvr_pkg::tcomp_t [2:0] t2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_r <= q0_r;
      v1_r <= v0_r;
      w1_r <= w0_r;
      q2_r <= q1_r;
      v2_r <= v1_r;
      w2_r <= w1_r;
      for (int i = 0; i < 3; i++) begin
        t2_r[i] <= qvr_pkg::round_t(xp1_r.pos[i], xp1_r.neg[i]);
      end
    end
  end

  // Stage 3: products of q x T and rot_w * T.
  qvr_pkg::xprod_t       xp3_r;
  qvr_pkg::prod_t  [2:0] wt3_r;

  qvr_xprod u_xprod_qt (
    .clk    (clk),
    .en     (adv),
    .a      (q2_r),
    .b      (t2_r),
    .prod_r (xp3_r)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      v3_r <= v2_r;
      w3_r <= w2_r;
      for (int i = 0; i < 3; i++) begin
        wt3_r[i] <= qvr_pkg::prod_t'(rot_w_r) * qvr_pkg::prod_t'(t2_r[i]);
      end
    end
  end

  // Stage 4: sum the three terms at 2^-14 scale and round once.
  localparam int SW = qvr_pkg::SW;
  qvr_pkg::rcomp_t [2:0] r4_r;
  qvr_pkg::rcomp_t [2:0] r4_nxt;

  always_comb begin
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] shifted;
    for (int i = 0; i < 3; i++) begin
      sum = SW'(wt3_r[i]) + SW'(xp3_r.pos[i]) - SW'(xp3_r.neg[i])
          + SW'(64'sd1 <<< (qvr_pkg::FRAC - 1));
      shifted   = sum >>> qvr_pkg::FRAC;
      r4_nxt[i] = shifted[qvr_pkg::RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r4_r <= r4_nxt;
      v4_r <= v3_r;
      w4_r <= w3_r;
    end
  end

  // Stage 5: add, clamp and hold the result for the output handshake.
  qvr_pkg::result_t res_r;

  qvr_sat u_sat (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_in (vld_r[4]),
    .r      (r4_r),
    .v      (v4_r),
    .w      (w4_r),
    .vld_r  (out_tvalid),
    .res_r  (res_r)
  );

  assign out_tdata = {res_r.w, res_r.v[2], res_r.v[1], res_r.v[0]};
  assign out_tuser = res_r.saturated;

endmodule

FILE: design/qvr_checker.sv
// Port-level checks for quaternion_vector_rotation, attached by bind below.
// Depends only on the top level's ports.
module qvr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Ready follows the output register: take a request whenever it is free or drains.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output stage");

  // A request taken with no stall in between reaches the output once it has passed every stage.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_tvalid && in_tready, 6) && $past(rst_n, 5) && $past(rst_n, 4)
      && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)
      && $past(in_tready, 5) && $past(in_tready, 4) && $past(in_tready, 3)
      && $past(in_tready, 2) && $past(in_tready, 1)
    |-> out_tvalid)
    else $error("result missing after pipeline latency");

  // The clamp flag implies some rotated component sits at a limit.
  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata[15:0] == 16'h7fff) || (out_tdata[15:0] == 16'h8000) ||
      (out_tdata[31:16] == 16'h7fff) || (out_tdata[31:16] == 16'h8000) ||
      (out_tdata[47:32] == 16'h7fff) || (out_tdata[47:32] == 16'h8000))
    else $error("saturated set without a clamped component");

  // Nothing leaves right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind quaternion_vector_rotation qvr_checker u_qvr_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for quaternion_vector_rotation: directed table plus random vectors,
// every result checked against its typed expectation or an in-bench fixed-point rotation predictor.
// Depends on qvr_pkg and the design under design/.
module tb_top;

  localparam logic MODE_FWD  = 1'b0;
  localparam logic MODE_INV  = 1'b1;
  localparam logic TYPED     = 1'b1;  // row carries its own expected result
  localparam logic PREDICTED = 1'b0;  // row is checked against the predictor
  localparam int   LIMIT_CYCLES = 400000;
  localparam int   PHASES = 10;
  localparam int   ITEMS_PER_PHASE = 130;
  localparam int   REPORT_MAX = 30;

  typedef enum logic [0:0] {ROW_ITEM, ROW_QUAT} row_kind_t;

  // For ROW_ITEM a..d are vec_x, vec_y, vec_z, vec_w.
  // For ROW_QUAT a..d are rot_w, rot_x, rot_y, rot_z.
  typedef struct packed {
    row_kind_t       kind;
    logic            mode;
    qvr_pkg::vcomp_t a, b, c, d;
    logic            typed;
    qvr_pkg::vcomp_t ex, ey, ez;
    logic            esat;
  } stim_row_t;

  typedef struct packed {
    qvr_pkg::vcomp_t x, y, z, w;
    logic            sat;
  } rot_out_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // vec_x [15:0], vec_y [31:16], vec_z [47:32], vec_w [63:48]
  logic [0:0]  in_tuser;   // mode [0]
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // out_x [15:0], out_y [31:16], out_z [47:32], out_w [63:48]
  logic [0:0]  out_tuser;  // saturated [0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Shadow of the rotation registers, reset value is the identity rotation.
  qvr_pkg::vcomp_t quat_w = 16'sh4000;
  qvr_pkg::vcomp_t quat_x = 16'sh0000;
  qvr_pkg::vcomp_t quat_y = 16'sh0000;
  qvr_pkg::vcomp_t quat_z = 16'sh0000;

  rot_out_t rot_pending[$];  // expected rotations, oldest first
  int       n_errors = 0;
  int       cycle_count = 0;
  bit       tight_run = 1'b0;  // no sender gaps while set
  bit       valid_up = 1'b0;   // mirrors the last value put on in_tvalid

  stim_row_t directed_rows [21] = '{
    // identity rotation straight out of reset: output equals input
    '{ROW_ITEM, MODE_FWD, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
      TYPED, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0},
    '{ROW_ITEM, MODE_FWD, 16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF,
      TYPED, 16'sh7FFF, 16'sh8000, 16'sh0001, 1'b0},
    '{ROW_ITEM, MODE_INV, 16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh5A5A,
      TYPED, 16'sh8000, 16'sh7FFF, 16'shFFFF, 1'b0},
    '{ROW_ITEM, MODE_INV, 16'shFFFF, 16'sh0000, 16'sh7FFF, 16'sh8000,
      TYPED, 16'shFFFF, 16'sh0000, 16'sh7FFF, 1'b0},
    // half turn about x: (x, y, z) -> (x, -y, -z), exact in fixed point
    '{ROW_QUAT, MODE_FWD, 16'sh0000, 16'sh4000, 16'sh0000, 16'sh0000,
      PREDICTED, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0},
    '{ROW_ITEM, MODE_FWD, 16'sd100, 16'sd200, -16'sd300, 16'sd7,
      TYPED, 16'sd100, -16'sd200, 16'sd300, 1'b0},
    // negating the most negative component clamps
    '{ROW_ITEM, MODE_FWD, 16'sh0001, 16'sh8000, 16'sh7FFF, 16'sh0000,
      TYPED, 16'sh0001, 16'sh7FFF, 16'sh8001, 1'b1},
    '{ROW_ITEM, MODE_INV, 16'sh0005, 16'sh8000, 16'sh8000, 16'shFFFF,
      TYPED, 16'sh0005, 16'sh7FFF, 16'sh7FFF, 1'b1},
    '{ROW_ITEM, MODE_INV, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh0000,
      TYPED, 16'sh7FFF, 16'sh8001, 16'sh8001, 1'b0},
    // non-unit quaternion, every part most negative; inverse needs +2.0
    '{ROW_QUAT, MODE_FWD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
      PREDICTED, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0},
    '{ROW_ITEM, MODE_FWD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
      PREDICTED, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0},
    '{ROW_ITEM, MODE_INV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
      PREDICTED, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0},
    '{ROW_ITEM, MODE_INV, 16'sh7FFF, 16'sh8000, 16'sh0001, 16'sh1234,
      PREDICTED, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0},
    '{ROW_ITEM, MODE_FWD, 16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001,
      PREDICTED, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0},
    // non-unit quaternion, every part most positive
    '{ROW_QUAT, MODE_FWD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
      PREDICTED, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0},
    '{ROW_ITEM, MODE_FWD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
      PREDICTED, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0},
    '{ROW_ITEM, MODE_INV, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000,
      PREDICTED, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0},
    // quarter turn about z, rounded parts
    '{ROW_QUAT, MODE_FWD, 16'sd11585, 16'sh0000, 16'sh0000, 16'sd11585,
      PREDICTED, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0},
    '{ROW_ITEM, MODE_FWD, 16'sd1000, 16'sh0000, 16'sh0000, 16'sh0000,
      PREDICTED, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0},
    '{ROW_ITEM, MODE_INV, 16'sh0000, 16'sd1000, -16'sd1000, 16'sh00FF,
      PREDICTED, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0},
    '{ROW_ITEM, MODE_FWD, 16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh0000,
      PREDICTED, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0}
  };

  quaternion_vector_rotation i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Round x / 2^sh to nearest, ties toward plus infinity.
  function automatic longint round_up_shift(longint x, int sh);
    return (x + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // v' = v + w*T + q x T with T = round(2 (q x v)); conjugate q in inverse mode.
  function automatic rot_out_t rotate_vector(logic inv, qvr_pkg::vcomp_t vx,
                                             qvr_pkg::vcomp_t vy, qvr_pkg::vcomp_t vz,
                                             qvr_pkg::vcomp_t vw);
    longint          v[3], q[3], t[3], c[3];
    longint          s;
    qvr_pkg::vcomp_t r[3];
    rot_out_t        res;
    int              i;
    v[0] = longint'(vx);
    v[1] = longint'(vy);
    v[2] = longint'(vz);
    q[0] = longint'(quat_x);
    q[1] = longint'(quat_y);
    q[2] = longint'(quat_z);
    res.sat = 1'b0;
    for (i = 0; i < 3; i++) if (inv) q[i] = -q[i];
    // axis i of a x b is a[i+1] b[i+2] - a[i+2] b[i+1], indexes mod 3
    for (i = 0; i < 3; i++) c[i] = q[(i+1)%3] * v[(i+2)%3] - q[(i+2)%3] * v[(i+1)%3];
    for (i = 0; i < 3; i++) t[i] = round_up_shift(c[i], qvr_pkg::FRAC - 1);
    for (i = 0; i < 3; i++) begin
      s = longint'(quat_w) * t[i] + q[(i+1)%3] * t[(i+2)%3] - q[(i+2)%3] * t[(i+1)%3];
      s = v[i] + round_up_shift(s, qvr_pkg::FRAC);
      if (s > 32767) begin
        s = 32767;
        res.sat = 1'b1;
      end else if (s < -32768) begin
        s = -32768;
        res.sat = 1'b1;
      end
      r[i] = qvr_pkg::vcomp_t'(s);
    end
    res.x = r[0];
    res.y = r[1];
    res.z = r[2];
    res.w = vw;
    return res;
  endfunction

  // Mostly back to back, sometimes a short gap, now and then a long one.
  function automatic int idle_cycles();
    int pick;
    pick = int'($urandom_range(0, 99));
    if (pick < 55) return 0;
    if (pick < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  function automatic qvr_pkg::vcomp_t rand_comp();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return qvr_pkg::vcomp_t'($urandom);
      5, 6, 7:       return qvr_pkg::vcomp_t'(int'($urandom_range(0, 2000)) - 1000);
      8:             return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default:       return qvr_pkg::vcomp_t'(int'($urandom_range(0, 2)) - 1);
    endcase
  endfunction

  // Quaternion part for one random phase; style picks the flavor.
  function automatic qvr_pkg::vcomp_t quat_part(int style, bit is_scalar);
    case (style)
      0: return qvr_pkg::vcomp_t'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return 16'sh0000;
          3:       return 16'sh4000;
          default: return 16'shC000;
        endcase
      end
      2: return qvr_pkg::vcomp_t'(int'($urandom_range(0, 23170)) - 11585);
      default: begin
        if (is_scalar) return qvr_pkg::vcomp_t'(int'($urandom_range(14000, 16384)));
        return qvr_pkg::vcomp_t'(int'($urandom_range(0, 8000)) - 4000);
      end
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input qvr_pkg::vcomp_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Load all four rotation registers; call only with the pipeline empty.
  task automatic write_quat(input qvr_pkg::vcomp_t w, input qvr_pkg::vcomp_t x,
                            input qvr_pkg::vcomp_t y, input qvr_pkg::vcomp_t z);
    write_reg(qvr_pkg::REG_ROT_W, w);
    write_reg(qvr_pkg::REG_ROT_X, x);
    write_reg(qvr_pkg::REG_ROT_Y, y);
    write_reg(qvr_pkg::REG_ROT_Z, z);
    cfg_valid <= 1'b0;
    quat_w = w;
    quat_x = x;
    quat_y = y;
    quat_z = z;
  endtask

  // Present one vector request, hold it until taken, then log its expectation.
  task automatic send_vector(input logic m, input qvr_pkg::vcomp_t vx,
                             input qvr_pkg::vcomp_t vy, input qvr_pkg::vcomp_t vz,
                             input qvr_pkg::vcomp_t vw,
                             input logic use_typed, input rot_out_t typed_exp);
    int gap;
    gap = tight_run ? 0 : idle_cycles();
    if (gap > 0) begin
      if (valid_up) in_tvalid <= 1'b0;
      valid_up = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {vw, vz, vy, vx};
    in_tuser  <= m;
    valid_up = 1'b1;
    do @(posedge clk); while (!in_tready);
    rot_pending.push_back(use_typed ? typed_exp : rotate_vector(m, vx, vy, vz, vw));
  endtask

  // Drop valid and wait until every request has come back out.
  task automatic wait_drained();
    if (valid_up) in_tvalid <= 1'b0;
    valid_up = 1'b0;
    while (rot_pending.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      n_errors++;
      if (n_errors <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Stimulus: reset, directed table, then random phases with fresh rotations.
  initial begin
    stim_row_t row;
    rot_out_t  typed_exp;
    int        style;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = qvr_pkg::REG_ROT_W;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == ROW_QUAT) begin
        wait_drained();
        write_quat(row.a, row.b, row.c, row.d);
      end else begin
        typed_exp = '{x: row.ex, y: row.ey, z: row.ez, w: row.d, sat: row.esat};
        send_vector(row.mode, row.a, row.b, row.c, row.d, row.typed, typed_exp);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      style = ph % 4;
      write_quat(quat_part(style, 1'b1), quat_part(style, 1'b0),
                 quat_part(style, 1'b0), quat_part(style, 1'b0));
      // every third phase streams without sender gaps
      tight_run = (ph % 3 == 1);
      repeat (ITEMS_PER_PHASE)
        send_vector(1'($urandom_range(0, 1)), rand_comp(), rand_comp(), rand_comp(),
                    qvr_pkg::vcomp_t'($urandom), PREDICTED, '0);
    end

    wait_drained();
    // hold a little longer to catch any stray result
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Receiver: ready bursts, mostly short, now and then a long one,
  // separated by stalls of random length.
  initial begin
    int n;
    out_tready = 1'b0;
    forever begin
      n = ($urandom_range(0, 7) == 0) ? int'($urandom_range(100, 300))
                                      : int'($urandom_range(1, 12));
      repeat (n) begin
        @(posedge clk);
        out_tready <= 1'b1;
      end
      n = idle_cycles();
      repeat (n) begin
        @(posedge clk);
        out_tready <= 1'b0;
      end
    end
  end

  // Compare each result with the oldest expectation, field by field.
  always @(posedge clk) begin
    rot_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (rot_pending.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_MAX)
          $display("%0t: result with nothing pending, expected none, got %h / %b",
                   $time, out_tdata, out_tuser);
      end else begin
        want = rot_pending.pop_front();
        check_field("out_x", int'(want.x), int'(qvr_pkg::vcomp_t'(out_tdata[15:0])));
        check_field("out_y", int'(want.y), int'(qvr_pkg::vcomp_t'(out_tdata[31:16])));
        check_field("out_z", int'(want.z), int'(qvr_pkg::vcomp_t'(out_tdata[47:32])));
        check_field("out_w", int'(want.w), int'(qvr_pkg::vcomp_t'(out_tdata[63:48])));
        check_field("saturated", int'(want.sat), int'(out_tuser[0]));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb_top: errors");
      $finish;
    end
  end

endmodule
